// File: rtl/pfm_pkg.sv
package pfm_pkg;

	localparam int TIME_BITS_DEFAULT = 48;
	localparam int NOW_BITS = 48;
	localparam int COUNT_BITS = 32;
	localparam int VOLUME_BITS = 64;
	localparam int RATE_BITS = 52;
	localparam int STEP_BITS = $clog2(RATE_BITS);
	localparam int OUT_DATA_BITS = 152;
	localparam int ADDR_BITS = 3;

	localparam logic [31:0] VPP_RESET = 32'd65536;
	localparam logic [31:0] MIN_RATE_RESET = 32'd3277;
	localparam logic [19:0] US_PER_SECOND = 20'd1000000;
	localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

	localparam logic [1:0] CMD_PULSE = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_ZERO = 2'd2;

	localparam logic REG_VPP = 1'b0;
	localparam logic REG_MIN_RATE = 1'b1;

	typedef struct packed {
		logic load;
		logic calc;
		logic step;
		logic finish;
	} pfm_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} pfm_status_t;

endpackage

// File: rtl/pfm_regs.sv
module pfm_regs import pfm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output logic [31:0]          vpp,
	output logic [31:0]          min_rate
);

	logic [31:0] vpp_q;
	logic [31:0] min_rate_q;
	logic        wr_en;

	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpp_q <= VPP_RESET;
			min_rate_q <= MIN_RATE_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_VPP) begin
				vpp_q <= pwdata;
			end else begin
				min_rate_q <= pwdata;
			end
		end
	end

	assign prdata = (paddr[2] == REG_MIN_RATE) ? min_rate_q : vpp_q;
	assign vpp = vpp_q;
	assign min_rate = min_rate_q;

endmodule

// File: rtl/pfm_ctrl.sv
module pfm_ctrl import pfm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  pfm_status_t stat,
	output pfm_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= ST_CALC;
						ready_q <= 1'b0;
					end
				end
				ST_CALC: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (stat.div_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

	always_comb begin
		cmd.load = s_tvalid && ready_q;
		cmd.calc = (state_q == ST_CALC);
		cmd.step = (state_q == ST_DIV);
		cmd.finish = (state_q == ST_DONE) && stat.out_free;
	end

endmodule

// File: rtl/pfm_datapath.sv
module pfm_datapath import pfm_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pfm_cmd_t                 cmd,
	output pfm_status_t              stat,
	input  logic [NOW_BITS-1:0]      s_tdata,
	input  logic [1:0]               s_tuser,
	input  logic [31:0]              vpp,
	input  logic [31:0]              min_rate,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic                     m_tuser
);

	logic [TIME_BITS-1:0]   now_in;
	logic [TIME_BITS-1:0]   now_q;
	logic [TIME_BITS-1:0]   last_time_q;
	logic [TIME_BITS-1:0]   last_intv_q;
	logic [TIME_BITS-1:0]   since;
	logic [TIME_BITS-1:0]   divisor;
	logic [TIME_BITS-1:0]   divisor_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   seen_q;
	logic                   zero_div_q;
	logic [RATE_BITS-1:0]   dividend;
	logic [VOLUME_BITS-1:0] volume;
	logic [VOLUME_BITS-1:0] volume_q;
	logic [RATE_BITS-1:0]   quo_q;
	logic [TIME_BITS-1:0]   rem_q;
	logic [TIME_BITS:0]     trial;
	logic [TIME_BITS:0]     diff;
	logic                   fits;
	logic [STEP_BITS-1:0]   cnt_q;
	logic [RATE_BITS-1:0]   rate;
	logic                   sat;
	logic [COUNT_BITS-1:0]  pulse_o_q;
	logic [VOLUME_BITS-1:0] volume_o_q;
	logic [RATE_BITS-1:0]   rate_o_q;
	logic                   sat_o_q;
	logic                   m_tvalid_q;

	assign now_in = TIME_BITS'(s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			seen_q <= 1'b0;
			last_time_q <= '0;
			last_intv_q <= '0;
		end else if (cmd.load) begin
			case (s_tuser)
				CMD_PULSE: begin
					if (count_q != '1) begin
						count_q <= count_q + 1'b1;
					end
					if (seen_q) begin
						last_intv_q <= now_in - last_time_q;
					end
					seen_q <= 1'b1;
					last_time_q <= now_in;
				end
				CMD_ZERO: begin
					count_q <= '0;
					seen_q <= 1'b0;
					last_time_q <= '0;
					last_intv_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_in;
		end
	end

	assign since = now_q - last_time_q;
	assign divisor = (since < last_intv_q) ? last_intv_q : since;
	assign dividend = RATE_BITS'(vpp) * RATE_BITS'(US_PER_SECOND);
	assign volume = VOLUME_BITS'(count_q) * VOLUME_BITS'(vpp);

	assign trial = {rem_q, quo_q[RATE_BITS-1]};
	assign diff = trial - {1'b0, divisor_q};
	assign fits = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			divisor_q <= divisor;
			zero_div_q <= (divisor == '0);
			volume_q <= volume;
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			quo_q <= {quo_q[RATE_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.calc) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign stat.div_last = (cnt_q == STEP_BITS'(RATE_BITS - 1));
	assign stat.out_free = !m_tvalid_q || m_tready;

	always_comb begin
		rate = '0;
		sat = 1'b0;
		if (seen_q) begin
			if (zero_div_q) begin
				rate = RATE_MAX;
				sat = 1'b1;
			end else if (quo_q >= RATE_BITS'(min_rate)) begin
				rate = quo_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pulse_o_q <= count_q;
			volume_o_q <= volume_q;
			rate_o_q <= rate;
			sat_o_q <= sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'b0, rate_o_q, volume_o_q, pulse_o_q};
	assign m_tuser = sat_o_q;

endmodule

// File: rtl/pulse_flow_meter_unit.sv
// Channel  | Direction | Handshake          | Payload
// s_axis   | in        | s_tvalid/s_tready  | tdata now_us, tuser command
// m_axis   | out       | m_tvalid/m_tready  | tdata pulse_total/volume/flow_rate, tuser sat
// apb      | in        | psel/penable       | volume_per_pulse at 0x0, min_rate at 0x4
//
// An item passes from acceptance to a valid result through the interval compare and the
// two multiplies, 52 steps of the radix-2 divider and the load of the output register,
// which waits until the output register is free. s_tready returns with the output load,
// so the next word is taken only after the previous result has been loaded.
// Reset clears the meter state and the handshake logic and loads the register defaults.
// A result waits in the output register while m_tready is low; the next item is taken
// once the pending result has been loaded there.
module pulse_flow_meter_unit import pfm_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [NOW_BITS-1:0]      s_tdata,  // now_us [47:0]
	input  logic [1:0]               s_tuser,  // command [1:0]
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,  // pulse_total [31:0], volume [95:32],
	                                           // flow_rate [147:96], zero [151:148]
	output logic                     m_tuser,  // rate_saturated [0]
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_BITS-1:0]     paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	pfm_cmd_t    cmd;
	pfm_status_t stat;
	logic [31:0] vpp;
	logic [31:0] min_rate;

	pfm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.vpp      (vpp),
		.min_rate (min_rate)
	);

	pfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfm_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.vpp      (vpp),
		.min_rate (min_rate),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(m_tvalid && !m_tready))
		else $error("pending result overwritten");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[147:96] == RATE_MAX))
		else $error("saturated rate is not full scale");

	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !(cmd.finish || cmd.calc || cmd.load))
		else $error("divider step overlaps another command");

endmodule

// File: verif/tb_pulse_flow_meter_unit.sv
module tb_pulse_flow_meter_unit;
	import pfm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int MAX_PRINTED = 50;

	typedef struct {
		logic [COUNT_BITS-1:0]  pulse_total;
		logic [VOLUME_BITS-1:0] volume;
		logic [RATE_BITS-1:0]   flow_rate;
		logic                   saturated;
	} reading_t;

	// Tracks the meter state and holds the readings that the block still owes.
	class meter_tracker;
		logic [31:0]           vpp;
		logic [31:0]           rate_floor;
		logic [COUNT_BITS-1:0] pulses;
		bit                    seen;
		logic [NOW_BITS-1:0]   last_time;
		logic [NOW_BITS-1:0]   last_gap;
		reading_t              readings_due[$];
		int                    mismatch_count;

		function new();
			vpp = VPP_RESET;
			rate_floor = MIN_RATE_RESET;
			pulses = '0;
			seen = 1'b0;
			last_time = '0;
			last_gap = '0;
			mismatch_count = 0;
		endfunction

		function void set_register(logic idx, logic [31:0] value);
			if (idx == REG_VPP) begin
				vpp = value;
			end else begin
				rate_floor = value;
			end
		endfunction

		function int pending();
			return readings_due.size();
		endfunction

		function void note_word(logic [1:0] cmd, logic [NOW_BITS-1:0] now);
			reading_t            r;
			logic [NOW_BITS-1:0] since;
			logic [NOW_BITS-1:0] divisor;
			logic [63:0]         quotient;
			if (cmd == CMD_PULSE) begin
				if (pulses != '1)
					pulses++;
				if (seen)
					last_gap = now - last_time;
				seen = 1'b1;
				last_time = now;
			end else if (cmd == CMD_ZERO) begin
				pulses = '0;
				seen = 1'b0;
				last_time = '0;
				last_gap = '0;
			end
			r.pulse_total = pulses;
			r.volume = 64'(pulses) * 64'(vpp);
			r.flow_rate = '0;
			r.saturated = 1'b0;
			if (seen) begin
				since = now - last_time;
				divisor = (since < last_gap) ? last_gap : since;
				if (divisor == '0) begin
					r.flow_rate = RATE_MAX;
					r.saturated = 1'b1;
				end else begin
					quotient = (64'(vpp) * 64'd1000000) / 64'(divisor);
					if (quotient >= 64'(rate_floor))
						r.flow_rate = quotient[RATE_BITS-1:0];
				end
			end
			readings_due.push_back(r);
		endfunction

		task flag_mismatch(string what);
			if (mismatch_count < MAX_PRINTED)
				$display("%0t mismatch: %s", $realtime, what);
			mismatch_count++;
		endtask

		task check_word(logic [OUT_DATA_BITS-1:0] data, logic sat);
			reading_t r;
			if (readings_due.size() == 0) begin
				flag_mismatch($sformatf("word with no reading due, data %h", data));
				return;
			end
			r = readings_due.pop_front();
			if (data[31:0] !== r.pulse_total)
				flag_mismatch($sformatf("pulse_total %h, want %h", data[31:0], r.pulse_total));
			if (data[95:32] !== r.volume)
				flag_mismatch($sformatf("volume %h, want %h", data[95:32], r.volume));
			if (data[147:96] !== r.flow_rate)
				flag_mismatch($sformatf("flow_rate %h, want %h", data[147:96], r.flow_rate));
			if (data[151:148] !== 4'd0)
				flag_mismatch($sformatf("fill bits %h, want 0", data[151:148]));
			if (sat !== r.saturated)
				flag_mismatch($sformatf("rate_saturated %b, want %b", sat, r.saturated));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [NOW_BITS-1:0]      s_tdata = '0;
	logic [1:0]               s_tuser = CMD_QUERY;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tuser;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_BITS-1:0]     paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;

	meter_tracker        sb = new();
	bit                  calm = 1'b0;
	int                  sent_count = 0;
	logic [NOW_BITS-1:0] stamp = '0;

	pulse_flow_meter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_word(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata, m_tuser);
		end
	end

	initial begin
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30) + (($urandom_range(0, 7) == 0) ? 200 : 0))
				@(posedge clk);
			if (!calm && $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	function automatic logic [NOW_BITS-1:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [NOW_BITS-1:0] pick_period();
		case ($urandom_range(0, 4))
			0: begin
				return 48'($urandom_range(1, 16));
			end
			1: begin
				return 48'($urandom_range(17, 5000));
			end
			2: begin
				return 48'($urandom_range(5001, 2000000));
			end
			3: begin
				return 48'($urandom);
			end
			default: begin
				return rand48() >> $urandom_range(0, 20);
			end
		endcase
	endfunction

	task automatic send_word(input logic [1:0] cmd, input logic [NOW_BITS-1:0] now);
		if (!calm && (sent_count % 128) < 80 && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= now;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value)
			sb.flag_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_meter(input logic [31:0] vpp, input logic [31:0] floor_rate);
		wait_drained();
		write_register(REG_VPP, vpp);
		write_register(REG_MIN_RATE, floor_rate);
	endtask

	task automatic run_directed();
		send_word(CMD_QUERY, 48'd0);
		send_word(CMD_PULSE, 48'd100);
		send_word(CMD_QUERY, 48'd100);
		send_word(CMD_QUERY, 48'd1100);
		send_word(CMD_PULSE, 48'd2100);
		send_word(CMD_QUERY, 48'd2100);
		send_word(CMD_SPARE, 48'd2600);
		send_word(CMD_PULSE, 48'd2101);
		send_word(CMD_QUERY, 48'd50);
		send_word(CMD_ZERO, 48'hFFFF_FFFF_FFFF);
		send_word(CMD_PULSE, 48'hFFFF_FFFF_FFF0);
		send_word(CMD_PULSE, 48'h0000_0000_0010);
		send_word(CMD_QUERY, 48'hFFFF_FFFF_FFFF);
		send_word(CMD_ZERO, 48'd0);
		send_word(CMD_QUERY, 48'd0);
		send_word(CMD_PULSE, 48'hAAAA_AAAA_AAAA);
		send_word(CMD_PULSE, 48'h5555_5555_5555);
		send_word(CMD_PULSE, 48'h5555_5555_5555);
		s_tvalid <= 1'b0;
	endtask

	task automatic run_random(input int n);
		logic [NOW_BITS-1:0] period;
		logic [1:0]          cmd;
		int                  pick;
		period = pick_period();
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				period = pick_period();
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				cmd = CMD_PULSE;
				stamp += period + 48'($urandom_range(0, 15));
			end else if (pick < 78) begin
				cmd = CMD_QUERY;
				if ($urandom_range(0, 1) != 0)
					stamp += period << 1;
				else
					stamp += period >> $urandom_range(0, 4);
			end else if (pick < 84) begin
				cmd = CMD_PULSE;
			end else if (pick < 88) begin
				cmd = CMD_ZERO;
			end else if (pick < 92) begin
				cmd = CMD_SPARE;
				stamp += period;
			end else begin
				cmd = 2'($urandom_range(0, 3));
				stamp = rand48();
			end
			send_word(cmd, stamp);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		#10ms;
		$display("pulse_flow_meter_unit regression: fail");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(150);
		set_meter(32'd0, 32'd0);
		run_random(150);
		set_meter(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(150);
		set_meter(32'hFFFF_FFFF, 32'd0);
		run_random(150);
		set_meter($urandom, $urandom_range(0, 200000));
		run_random(150);
		set_meter(VPP_RESET, MIN_RATE_RESET);
		run_random(150);
		set_meter($urandom, $urandom >> $urandom_range(0, 31));
		calm = 1'b1;
		run_random(200);
		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("pulse_flow_meter_unit regression: pass");
		end else begin
			$display("pulse_flow_meter_unit regression: fail");
		end
		$finish;
	end

endmodule
